### design/grid_wall_segment_extract_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wall segment extractor
// Shared helpers that wrap a concurrent assertion with its clock, reset
// handling and error report.
// ----------------------------------------------------------------------------
`ifndef GRID_WALL_SEGMENT_EXTRACT_CORE_ASSERT_SVH
`define GRID_WALL_SEGMENT_EXTRACT_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define GWSE_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gwse assertion failed: same-cycle check");

// Next-cycle implication, switched off while reset is high.
`define GWSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gwse assertion failed: next-cycle check");

// Next-cycle implication that is also checked across reset.
`define GWSE_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("gwse assertion failed: reset check");

`endif

### design/gwse_pkg.sv
// ----------------------------------------------------------------------------
// gwse_pkg
// Types, constants and helpers shared by the wall segment extractor.
// ----------------------------------------------------------------------------
package gwse_pkg;

   // Grid geometry and derived widths.
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int COORD_W    = 6;
   localparam int CNT_W      = COORD_W + 1;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0]  REG_ROW_COUNT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0]  REG_COL_COUNT   = CSR_IDX_W'(1);
   localparam logic [CSR_DATA_W-1:0] ROW_COUNT_RESET = CSR_DATA_W'(27);
   localparam logic [CSR_DATA_W-1:0] COL_COUNT_RESET = CSR_DATA_W'(36);

   // Input operation codes.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Queue sizes.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic               opcode;
      logic [COORD_W-1:0] cell_row;
      logic [COORD_W-1:0] cell_col;
      logic               cell_value;
   } req_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] end_row;
      logic [COORD_W-1:0] end_col;
      logic               is_vertical;
      logic               scan_done;
   } rsp_item_type;

   // Grid size in use, already limited to the store.
   typedef struct packed {
      logic [CNT_W-1:0] rows;
      logic [CNT_W-1:0] cols;
   } cfg_type;

   // Classified command handed from the front to the back.
   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_REQUEST = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               value;
   } cmd_type;

   // Row-major address of a cell in the grid store.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
   endfunction

endpackage

### design/gwse_front.sv
// ----------------------------------------------------------------------------
// gwse_front
// Accepts input items, classifies them into commands and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
module gwse_front import gwse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         cmd_valid,
   input  logic         cmd_pop,
   output cmd_type      cmd
);

   cmd_type                 q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   cmd_type                 cmd_new;
   logic                    take;
   logic                    give;

   // Classify the item: a load outside the store only restarts the scan.
   always_comb begin
      cmd_new.row   = req_item.cell_row;
      cmd_new.col   = req_item.cell_col;
      cmd_new.value = req_item.cell_value;
      if (req_item.opcode == OP_REQUEST) begin
         cmd_new.kind = CMD_REQUEST;
      end else if ((CNT_W'(req_item.cell_row) < CNT_W'(MAX_ROWS)) &&
                   (CNT_W'(req_item.cell_col) < CNT_W'(MAX_COLS))) begin
         cmd_new.kind = CMD_LOAD;
      end else begin
         cmd_new.kind = CMD_RESTART;
      end
   end

   assign full      = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign take      = push && !full;
   assign give      = cmd_pop && cmd_valid;

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (take) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + CMDQ_PTR_W'(1);
      end
      if (give) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + CMDQ_PTR_W'(1);
      end
      priority if (take && !give) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (!take && give) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

### design/gwse_back.sv
// ----------------------------------------------------------------------------
// gwse_back
// Holds the grid store and runs the scan: it walks the cells one read per
// cycle, apart from a pause at each row crossing in the search, extends runs,
// clears consumed cells and produces one result item per request.
// ----------------------------------------------------------------------------
module gwse_back import gwse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output rsp_item_type rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_RUN    = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [COORD_W-1:0] scan_row_ff, scan_row_in;
   logic [COORD_W-1:0] scan_col_ff, scan_col_in;
   logic               vpend_ff, vpend_in;
   logic               finished_ff, finished_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [CNT_W-1:0]   ptr_row_ff, ptr_row_in;
   logic [CNT_W-1:0]   ptr_col_ff, ptr_col_in;
   logic [COORD_W-1:0] rd_row_ff, rd_row_in;
   logic [COORD_W-1:0] rd_col_ff, rd_col_in;
   logic [COORD_W-1:0] end_ff, end_in;
   logic               vert_ff, vert_in;

   // Grid store: one write and one registered read per cycle.
   logic               grid_mem [CELL_COUNT];
   logic               rd_bit_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic               mem_wd;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_ra;

   // Run and advance helpers.
   logic [CNT_W-1:0]   run_idx;
   logic [CNT_W-1:0]   run_lim;
   logic [COORD_W-1:0] data_idx;
   logic               run_hit;
   logic               run_stop;
   logic [CNT_W-1:0]   col_step;
   logic [CNT_W-1:0]   adv_row;
   logic [CNT_W-1:0]   adv_col;

   assign run_idx  = vert_ff ? ptr_row_ff : ptr_col_ff;
   assign run_lim  = vert_ff ? cfg.rows : cfg.cols;
   assign data_idx = vert_ff ? rd_row_ff : rd_col_ff;
   assign run_hit  = rd_valid_ff && rd_bit_ff;
   assign run_stop = (rd_valid_ff && !rd_bit_ff) || (!rd_valid_ff && (run_idx >= run_lim));
   assign mem_ra   = cell_addr(ptr_row_ff[COORD_W-1:0], ptr_col_ff[COORD_W-1:0]);

   // Scan position after the vertical run of the current cell.
   assign col_step = CNT_W'(scan_col_ff) + CNT_W'(1);
   assign adv_col  = (col_step >= cfg.cols) ? '0 : col_step;
   assign adv_row  = (col_step >= cfg.cols) ? CNT_W'(scan_row_ff) + CNT_W'(1) :
                     CNT_W'(scan_row_ff);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      vpend_in    = vpend_ff;
      finished_in = finished_ff;
      rd_valid_in = rd_valid_ff;
      ptr_row_in  = ptr_row_ff;
      ptr_col_in  = ptr_col_ff;
      rd_row_in   = rd_row_ff;
      rd_col_in   = rd_col_ff;
      end_in      = end_ff;
      vert_in     = vert_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_item    = '0;
      mem_we      = 1'b0;
      mem_wa      = '0;
      mem_wd      = 1'b0;
      mem_re      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_LOAD: begin
                     cmd_pop     = 1'b1;
                     mem_we      = 1'b1;
                     mem_wa      = cell_addr(cmd.row, cmd.col);
                     mem_wd      = cmd.value;
                     scan_row_in = '0;
                     scan_col_in = '0;
                     vpend_in    = 1'b0;
                     finished_in = 1'b0;
                  end
                  CMD_RESTART: begin
                     cmd_pop     = 1'b1;
                     scan_row_in = '0;
                     scan_col_in = '0;
                     vpend_in    = 1'b0;
                     finished_in = 1'b0;
                  end
                  CMD_REQUEST: begin
                     // Start only with room for the result item.
                     if (!rsp_full) begin
                        cmd_pop = 1'b1;
                        priority if (finished_ff) begin
                           rsp_push           = 1'b1;
                           rsp_item.scan_done = 1'b1;
                        end else if (vpend_ff) begin
                           state_in    = ST_RUN;
                           vert_in     = 1'b1;
                           ptr_row_in  = CNT_W'(scan_row_ff) + CNT_W'(1);
                           ptr_col_in  = CNT_W'(scan_col_ff);
                           end_in      = scan_row_ff;
                           rd_valid_in = 1'b0;
                        end else begin
                           state_in    = ST_SEARCH;
                           ptr_row_in  = CNT_W'(scan_row_ff);
                           ptr_col_in  = CNT_W'(scan_col_ff);
                           rd_valid_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            // Data for the previous read decides first; unless it starts a run, a read
            // goes out for the next cell of the row in the same cycle, if one is left.
            priority if (rd_valid_ff && rd_bit_ff) begin
               scan_row_in = rd_row_ff;
               scan_col_in = rd_col_ff;
               state_in    = ST_RUN;
               vert_in     = 1'b0;
               ptr_row_in  = CNT_W'(rd_row_ff);
               ptr_col_in  = CNT_W'(rd_col_ff) + CNT_W'(1);
               end_in      = rd_col_ff;
               rd_valid_in = 1'b0;
            end else if (ptr_row_ff >= cfg.rows) begin
               finished_in        = 1'b1;
               scan_row_in        = '0;
               scan_col_in        = '0;
               state_in           = ST_IDLE;
               rd_valid_in        = 1'b0;
               rsp_push           = 1'b1;
               rsp_item.scan_done = 1'b1;
            end else if (ptr_col_ff >= cfg.cols) begin
               ptr_col_in  = '0;
               ptr_row_in  = ptr_row_ff + CNT_W'(1);
               rd_valid_in = 1'b0;
            end else begin
               mem_re      = 1'b1;
               rd_valid_in = 1'b1;
               rd_row_in   = ptr_row_ff[COORD_W-1:0];
               rd_col_in   = ptr_col_ff[COORD_W-1:0];
               ptr_col_in  = ptr_col_ff + CNT_W'(1);
            end
         end

         ST_RUN: begin
            // A set cell extends the run and clears the cell before it.
            if (run_hit) begin
               mem_we = 1'b1;
               mem_wa = vert_ff ? cell_addr(end_ff, scan_col_ff) :
                                  cell_addr(scan_row_ff, end_ff);
               mem_wd = 1'b0;
               end_in = data_idx;
            end
            priority if (run_stop) begin
               state_in             = ST_IDLE;
               rd_valid_in          = 1'b0;
               rsp_push             = 1'b1;
               rsp_item.start_row   = scan_row_ff;
               rsp_item.start_col   = scan_col_ff;
               rsp_item.is_vertical = vert_ff;
               if (vert_ff) begin
                  rsp_item.end_row = end_ff;
                  rsp_item.end_col = scan_col_ff;
                  vpend_in         = 1'b0;
                  if (adv_row >= cfg.rows) begin
                     finished_in = 1'b1;
                     scan_row_in = '0;
                     scan_col_in = '0;
                  end else begin
                     scan_row_in = adv_row[COORD_W-1:0];
                     scan_col_in = adv_col[COORD_W-1:0];
                  end
               end else begin
                  rsp_item.end_row = scan_row_ff;
                  rsp_item.end_col = end_ff;
                  vpend_in         = 1'b1;
               end
            end else if (run_idx < run_lim) begin
               mem_re      = 1'b1;
               rd_valid_in = 1'b1;
               rd_row_in   = ptr_row_ff[COORD_W-1:0];
               rd_col_in   = ptr_col_ff[COORD_W-1:0];
               if (vert_ff) begin
                  ptr_row_in = ptr_row_ff + CNT_W'(1);
               end else begin
                  ptr_col_in = ptr_col_ff + CNT_W'(1);
               end
            end else begin
               rd_valid_in = 1'b0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_row_ff <= '0;
         scan_col_ff <= '0;
         vpend_ff    <= 1'b0;
         finished_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_row_ff <= scan_row_in;
         scan_col_ff <= scan_col_in;
         vpend_ff    <= vpend_in;
         finished_ff <= finished_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Walk pointers and run bookkeeping.
   always_ff @(posedge clock) begin
      ptr_row_ff <= ptr_row_in;
      ptr_col_ff <= ptr_col_in;
      rd_row_ff  <= rd_row_in;
      rd_col_ff  <= rd_col_in;
      end_ff     <= end_in;
      vert_ff    <= vert_in;
   end

   // Grid store ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_bit_ff <= grid_mem[mem_ra];
      end
   end

endmodule

### design/gwse_rsp_queue.sv
// ----------------------------------------------------------------------------
// gwse_rsp_queue
// Short result queue that parts the back end from the result receiver.
// ----------------------------------------------------------------------------
module gwse_rsp_queue import gwse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         full,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type head_item
);

   rsp_item_type          q_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] count_ff, count_in;
   logic                  take;
   logic                  give;

   assign full      = (count_ff == RSPQ_CNT_W'(RSPQ_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = q_ff[rd_ptr_ff];
   assign take      = push && !full;
   assign give      = pop && !empty;

   // Pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (take) begin
         wr_ptr_in = (wr_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + RSPQ_PTR_W'(1);
      end
      if (give) begin
         rd_ptr_in = (rd_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + RSPQ_PTR_W'(1);
      end
      priority if (take && !give) begin
         count_in = count_ff + RSPQ_CNT_W'(1);
      end else if (!take && give) begin
         count_in = count_ff - RSPQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/grid_wall_segment_extract_core.sv
// ----------------------------------------------------------------------------
// grid_wall_segment_extract_core
// Loads a binary occupancy grid and hands out wall segments on request.
//
// Input items enter through push/full with req_item; an item is taken when
// push is high and full is low. A load item writes one grid cell and
// restarts the scan; a request item yields exactly one result item.
// Result items leave through empty/pop with rsp_item, oldest first.
// Configuration writes use valid/ready with csr_index and csr_data; ready
// is always high, and writes belong to quiet periods between items.
// Each item is registered in the front queue, then the back end works on
// it: a load writes its cell, a request walks the single read port of the
// grid store one cell a cycle, pausing its reads where the scan crosses to
// the next row. The result is visible in the cycle after it is produced. A
// two-entry result queue lets the front keep accepting while a result waits;
// when it fills, requests hold in the front queue and full rises once that
// queue is full too.
// Reset empties both queues, clears the scan position and sets the grid
// size to 27 rows by 36 columns. The grid store is not cleared: cells must
// be loaded before they are scanned.
// ----------------------------------------------------------------------------
module grid_wall_segment_extract_core import gwse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_item_type          req_item,
   output logic                  empty,
   input  logic                  pop,
   output rsp_item_type          rsp_item,
   input  logic                  valid,
   output logic                  ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [CSR_DATA_W-1:0] row_count_ff, row_count_in;
   logic [CSR_DATA_W-1:0] col_count_ff, col_count_in;
   cfg_type               cfg;
   logic                  cmd_valid;
   logic                  cmd_pop;
   cmd_type               cmd;
   logic                  rsp_full;
   logic                  rsp_push;
   rsp_item_type          rsp_new;

   assign ready = 1'b1;

   // Configuration registers; unknown indexes are ignored.
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (valid) begin
         unique case (csr_index)
            REG_ROW_COUNT: row_count_in = csr_data;
            REG_COL_COUNT: col_count_in = csr_data;
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         col_count_ff <= COL_COUNT_RESET;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // Grid size in use, limited to the store.
   assign cfg.rows = (CNT_W'(row_count_ff) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) :
                     CNT_W'(row_count_ff);
   assign cfg.cols = (CNT_W'(col_count_ff) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) :
                     CNT_W'(col_count_ff);

   gwse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   gwse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_new)
   );

   gwse_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_new),
      .full      (rsp_full),
      .empty     (empty),
      .pop       (pop),
      .head_item (rsp_item)
   );

endmodule

### design/gwse_checker.sv
// ----------------------------------------------------------------------------
// gwse_checker
// Port-level checks on the wall segment extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_wall_segment_extract_core_assert.svh"

module gwse_checker import gwse_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         full,
   input logic         empty,
   input logic         pop,
   input rsp_item_type rsp_item
);

   // Reset leaves the result queue empty and the input side not full.
   `GWSE_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !full && empty)

   // A waiting result item holds until it is popped.
   `GWSE_ASSERT_NEXT(a_head_holds, clock, reset, !empty && !pop, !empty && $stable(rsp_item))

   // A vertical segment stays in one column and runs downward.
   `GWSE_ASSERT_SAME(a_vertical_shape, clock, reset, !empty && rsp_item.is_vertical, !rsp_item.scan_done && (rsp_item.start_col == rsp_item.end_col) && (rsp_item.end_row >= rsp_item.start_row))

   // A horizontal segment stays in one row and runs to the right.
   `GWSE_ASSERT_SAME(a_horizontal_shape, clock, reset, !empty && !rsp_item.is_vertical && !rsp_item.scan_done, (rsp_item.start_row == rsp_item.end_row) && (rsp_item.end_col >= rsp_item.start_col))

   // The end-of-scan item carries no coordinates.
   `GWSE_ASSERT_SAME(a_done_zero, clock, reset, !empty && rsp_item.scan_done, (rsp_item.start_row == '0) && (rsp_item.start_col == '0) && (rsp_item.end_row == '0) && (rsp_item.end_col == '0))

endmodule

bind grid_wall_segment_extract_core gwse_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
